// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");
// Antecedent on this edge implies consequent on the next one.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/skf_pkg.sv =====
package skf_pkg;

  localparam int SampleW   = 24;
  localparam int EstW      = 40;
  localparam int GainW     = 17;
  localparam int VarW      = 32;
  localparam int CfgIdxW   = 8;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 96;
  localparam int PredW     = 33;
  localparam int SumW      = 34;
  localparam int DiffW     = 41;
  localparam int NumW      = 50;
  localparam int ProdW     = 43;
  localparam int AccW      = 60;
  localparam int DeltaW    = 44;
  localparam int DivSteps  = 17;
  localparam int CntW      = 5;

  localparam logic [VarW-1:0]    ProcNoiseRst = 32'd655;
  localparam logic [VarW-1:0]    MeasNoiseRst = 32'd65536;
  localparam logic [GainW-1:0]   GainOne      = 17'd65536;
  localparam logic [CfgIdxW-1:0] RegProcNoise = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMeasNoise = 8'd1;

  // multiplier operand select
  localparam logic [1:0] MulDiffLo = 2'd0;
  localparam logic [1:0] MulDiffHi = 2'd1;
  localparam logic [1:0] MulPredLo = 2'd2;
  localparam logic [1:0] MulPredHi = 2'd3;

  // accumulator operation
  localparam logic [1:0] AccHold  = 2'd0;
  localparam logic [1:0] AccLoad  = 2'd1;
  localparam logic [1:0] AccAddHi = 2'd2;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       div_init;
    logic       div_step;
    logic       gain_set;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       delta_set;
    logic       est_set;
    logic       var_set;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== rtl/skf_ctrl.sv =====
module skf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  skf_pkg::status_t status,
  output skf_pkg::cmd_t    cmd
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StPrep = 4'd1;
  localparam logic [3:0] StInit = 4'd2;
  localparam logic [3:0] StDiv  = 4'd3;
  localparam logic [3:0] StGain = 4'd4;
  localparam logic [3:0] StM0   = 4'd5;
  localparam logic [3:0] StM1   = 4'd6;
  localparam logic [3:0] StM2   = 4'd7;
  localparam logic [3:0] StM3   = 4'd8;
  localparam logic [3:0] StM4   = 4'd9;
  localparam logic [3:0] StM5   = 4'd10;
  localparam logic [3:0] StDone = 4'd11;

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic [skf_pkg::CntW-1:0] cnt;

  assign s_tready = (state == StIdle);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = skf_pkg::MulDiffLo;
    cmd.acc_op = skf_pkg::AccHold;
    unique case (state)
      StIdle: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = StPrep;
        end
      end
      StPrep: begin
        cmd.prep = 1'b1;
        state_next = StInit;
      end
      StInit: begin
        cmd.div_init = 1'b1;
        state_next = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = StGain;
      end
      StGain: begin
        cmd.gain_set = 1'b1;
        state_next = StM0;
      end
      StM0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = skf_pkg::MulDiffLo;
        state_next = StM1;
      end
      StM1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = skf_pkg::MulDiffHi;
        cmd.acc_op = skf_pkg::AccLoad;
        state_next = StM2;
      end
      StM2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = skf_pkg::MulPredLo;
        cmd.acc_op = skf_pkg::AccAddHi;
        state_next = StM3;
      end
      StM3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = skf_pkg::MulPredHi;
        cmd.acc_op = skf_pkg::AccLoad;
        cmd.delta_set = 1'b1;
        state_next = StM4;
      end
      StM4: begin
        cmd.acc_op = skf_pkg::AccAddHi;
        cmd.est_set = 1'b1;
        state_next = StM5;
      end
      StM5: begin
        cmd.var_set = 1'b1;
        state_next = StDone;
      end
      StDone: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == StInit) begin
        cnt <= skf_pkg::CntW'(skf_pkg::DivSteps - 1);
      end else if (state == StDiv) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/skf_dp.sv =====
module skf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  skf_pkg::cmd_t                 cmd,
  output skf_pkg::status_t              status,
  input  logic [skf_pkg::InDataW-1:0]   s_tdata,
  input  logic                          cfg_valid,
  input  logic [skf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [skf_pkg::VarW-1:0]      cfg_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [skf_pkg::OutDataW-1:0]  m_tdata
);

  localparam int PadW = skf_pkg::OutDataW - skf_pkg::EstW - skf_pkg::GainW - skf_pkg::VarW;

  logic [skf_pkg::VarW-1:0]           proc_noise;
  logic [skf_pkg::VarW-1:0]           meas_noise;
  logic signed [skf_pkg::EstW-1:0]    est;
  logic [skf_pkg::VarW-1:0]           var_q;

  logic signed [skf_pkg::SampleW-1:0] smp;
  logic [skf_pkg::PredW-1:0]          pred;
  logic [skf_pkg::SumW-1:0]           sum;
  logic signed [skf_pkg::DiffW-1:0]   diff;
  logic [skf_pkg::SumW-1:0]           rem;
  logic [skf_pkg::GainW-1:0]          quo;
  logic [skf_pkg::GainW-1:0]          gain;
  logic signed [skf_pkg::ProdW-1:0]   prod;
  logic signed [skf_pkg::AccW-1:0]    acc;
  logic signed [skf_pkg::DeltaW-1:0]  delta;
  logic signed [skf_pkg::EstW-1:0]    est_new;
  logic [skf_pkg::VarW-1:0]           var_new;

  logic [skf_pkg::NumW-1:0]           num;
  logic [skf_pkg::SumW:0]             trial;
  logic                               fits;
  logic [skf_pkg::GainW-1:0]          gain_c;
  logic [skf_pkg::GainW-1:0]          inv_gain;
  logic signed [skf_pkg::GainW:0]     mul_a;
  logic signed [24:0]                 mul_b;
  logic signed [skf_pkg::AccW-1:0]    prod_ext;
  logic signed [skf_pkg::AccW-1:0]    acc_rnd;
  logic signed [skf_pkg::EstW+4:0]    est_sum;
  logic [skf_pkg::DeltaW-1:0]         var_full;

  assign status.out_free = !m_tvalid || m_tready;

  // gain numerator: P * 2^16 + S / 2, round half up
  assign num = {1'b0, pred, 16'b0} + skf_pkg::NumW'(sum[skf_pkg::SumW-1:1]);
  assign trial = {rem, quo[skf_pkg::GainW-1]};
  assign fits = (trial >= {1'b0, sum});

  always_comb begin
    if (sum == '0) begin
      gain_c = '0;
    end else if (quo > skf_pkg::GainOne) begin
      gain_c = skf_pkg::GainOne;
    end else begin
      gain_c = quo;
    end
  end

  assign inv_gain = skf_pkg::GainOne - gain;

  always_comb begin
    mul_a = (cmd.mul_sel == skf_pkg::MulPredLo || cmd.mul_sel == skf_pkg::MulPredHi) ?
            {1'b0, inv_gain} : {1'b0, gain};
    unique case (cmd.mul_sel)
      skf_pkg::MulDiffLo: mul_b = {1'b0, diff[23:0]};
      skf_pkg::MulDiffHi: mul_b = {{8{diff[skf_pkg::DiffW-1]}}, diff[skf_pkg::DiffW-1:24]};
      skf_pkg::MulPredLo: mul_b = {1'b0, pred[23:0]};
      default:            mul_b = {16'b0, pred[skf_pkg::PredW-1:24]};
    endcase
  end

  assign prod_ext = {{(skf_pkg::AccW - skf_pkg::ProdW){prod[skf_pkg::ProdW-1]}}, prod};
  assign acc_rnd  = acc + skf_pkg::AccW'(32768);
  assign est_sum  = {{5{est[skf_pkg::EstW-1]}}, est} + {delta[skf_pkg::DeltaW-1], delta};
  assign var_full = acc_rnd[skf_pkg::AccW-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_noise <= skf_pkg::ProcNoiseRst;
      meas_noise <= skf_pkg::MeasNoiseRst;
      est <= '0;
      var_q <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == skf_pkg::RegProcNoise) proc_noise <= cfg_data;
        if (cfg_index == skf_pkg::RegMeasNoise) meas_noise <= cfg_data;
      end
      if (cmd.commit) begin
        est <= est_new;
        var_q <= var_new;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp  <= s_tdata[skf_pkg::SampleW-1:0];
      pred <= {1'b0, var_q} + {1'b0, proc_noise};
    end
    if (cmd.prep) begin
      sum  <= {1'b0, pred} + {2'b0, meas_noise};
      diff <= {smp[skf_pkg::SampleW-1], smp, 16'b0} - {est[skf_pkg::EstW-1], est};
    end
    if (cmd.div_init) begin
      rem <= {1'b0, num[skf_pkg::NumW-1:skf_pkg::DivSteps]};
      quo <= num[skf_pkg::DivSteps-1:0];
    end else if (cmd.div_step) begin
      // restoring step; quotient bits shift in from below
      rem <= fits ? skf_pkg::SumW'(trial - {1'b0, sum}) : trial[skf_pkg::SumW-1:0];
      quo <= {quo[skf_pkg::GainW-2:0], fits};
    end
    if (cmd.gain_set) gain <= gain_c;
    if (cmd.mul_en) prod <= mul_a * mul_b;
    unique case (cmd.acc_op)
      skf_pkg::AccLoad:  acc <= prod_ext;
      skf_pkg::AccAddHi: acc <= acc + {prod_ext[skf_pkg::AccW-25:0], 24'b0};
      default:           acc <= acc;
    endcase
    if (cmd.delta_set) delta <= acc_rnd[skf_pkg::AccW-1:16];
    if (cmd.est_set) begin
      if (est_sum[skf_pkg::EstW+4:skf_pkg::EstW-1] == '0 ||
          est_sum[skf_pkg::EstW+4:skf_pkg::EstW-1] == '1) begin
        est_new <= est_sum[skf_pkg::EstW-1:0];
      end else if (est_sum[skf_pkg::EstW+4]) begin
        est_new <= {1'b1, {(skf_pkg::EstW-1){1'b0}}};
      end else begin
        est_new <= {1'b0, {(skf_pkg::EstW-1){1'b1}}};
      end
    end
    if (cmd.var_set) begin
      var_new <= (var_full[skf_pkg::DeltaW-1:skf_pkg::VarW] != '0) ? '1 :
                 var_full[skf_pkg::VarW-1:0];
    end
    if (cmd.commit) begin
      m_tdata <= {{PadW{1'b0}}, var_new, gain, est_new};
    end
  end

endmodule

// ===== rtl/scalar_kalman_filter_unit.sv =====
// Scalar Kalman filter: one result beat per sample beat.
// A new sample is taken only after the result of the previous one is loaded into the
// output register, and that load waits while the register still holds an unread result;
// each sample runs the 17-step restoring gain divider and then the shared-multiplier states.
// Reset (rst, synchronous): estimate and variance clear to zero, noise registers
// return to Q = 655 and R = 65536; the output register empties.
`include "assert_macros.svh"

module scalar_kalman_filter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [skf_pkg::InDataW-1:0]   s_tdata,   // [23:0] sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [skf_pkg::OutDataW-1:0]  m_tdata,   // [39:0] estimate, [56:40] gain,
                                                   // [88:57] variance, rest zero
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [skf_pkg::VarW-1:0]      cfg_data
);

  skf_pkg::cmd_t    cmd;
  skf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  skf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // one sample in flight at a time
  `ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // reported gain never exceeds one
  `ASSERT_ALWAYS(a_gain_range, !m_tvalid || (m_tdata[56:40] <= skf_pkg::GainOne))
  // a result is only loaded when the output register can take it
  `ASSERT_ALWAYS(a_no_overwrite, !cmd.commit || status.out_free)

endmodule
